// ===== rtl/core/tlpt_pkg.sv =====
// Shared types and constants of the two-level page table engine.
package tlpt_pkg;

  // Address split of a 32-bit virtual address
  localparam int unsigned VA_W      = 32;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned DIR_LSB   = 22;
  localparam int unsigned LEAF_LSB  = 12;
  localparam int unsigned DIR_DEPTH = 1024;
  localparam int unsigned LEAF_SPAN = 1024;
  localparam int unsigned FRAME_W   = 20;

  // Directory entry bit positions; the table index sits above them
  localparam int unsigned DIR_PRESENT = 0;
  localparam int unsigned DIR_USER    = 1;
  localparam int unsigned DIR_GLOBAL  = 2;
  localparam int unsigned DIR_TAB_LSB = 3;

  // Request codes
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_MAP    = 2'd1,
    CMD_UNMAP  = 2'd2
  } cmd_t;

  // Second-level entry
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               global_pg;
    logic               user;
    logic               rw;
    logic               present;
  } leaf_t;

  localparam int unsigned LEAF_W = $bits(leaf_t);

endpackage

// ===== rtl/core/tlpt_dir_mem.sv =====
// Directory memory: 1024 entries, one write and one registered read port.
module tlpt_dir_mem #(
  parameter int unsigned DATA_W = 5
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [tlpt_pkg::IDX_W-1:0]     waddr,
  input  logic [DATA_W-1:0]              wdata,
  input  logic [tlpt_pkg::IDX_W-1:0]     raddr,
  output logic [DATA_W-1:0]              rdata
);

  logic [DATA_W-1:0] mem [tlpt_pkg::DIR_DEPTH];

  // Write, and read with the read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tlpt_leaf_mem.sv =====
// Second-level entry memory for the whole table pool, one write and one registered read port.
module tlpt_leaf_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  tlpt_pkg::leaf_t       wdata,
  input  logic [ADDR_W-1:0]     raddr,
  output tlpt_pkg::leaf_t       rdata
);

  tlpt_pkg::leaf_t mem [DEPTH];

  // Write, and read with the read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/two_level_page_table_engine.sv =====
// Top level of the two-level page table engine: request sequencer and both memories.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | cmd, virt_addr, phys_page, flag_kernel, flag_writable
//   out_    | output    | out_valid/out_stall| ok, found_page
//
// A map, or a lookup or unmap whose directory entry is absent, finishes in ST_DIR; a lookup
// or unmap that reaches the leaf goes on to ST_LEAF: the directory read must return before
// the dependent leaf read is issued. No new item is taken before the last one is done.
// After reset a clearing pass walks every leaf address and zeroes both memories; no item
// is accepted meanwhile.
// The result sits in an output register; while the output is stalled, the next item's
// result waits in a pending register until the output frees up.
module two_level_page_table_engine #(
  parameter int unsigned TABLE_POOL = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_virt_addr,
  input  logic [19:0] in_phys_page,
  input  logic        in_flag_kernel,
  input  logic        in_flag_writable,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [19:0] out_found_page
);

  localparam int unsigned TBL_W      = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int unsigned CNT_W      = $clog2(TABLE_POOL + 1);
  localparam int unsigned LEAF_DEPTH = TABLE_POOL * tlpt_pkg::LEAF_SPAN;
  localparam int unsigned LEAF_AW    = $clog2(LEAF_DEPTH);
  localparam int unsigned DIR_W      = tlpt_pkg::DIR_TAB_LSB + TBL_W;
  localparam int unsigned IW         = tlpt_pkg::IDX_W;
  localparam int unsigned FW         = tlpt_pkg::FRAME_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIR,
    ST_LEAF,
    ST_DONE
  } state_t;

  state_t                state_r;
  logic [LEAF_AW-1:0]    clr_cnt_r;
  logic [CNT_W-1:0]      next_tab_r;
  logic [1:0]            cmd_r;
  logic [IW-1:0]         dir_idx_r;
  logic [IW-1:0]         leaf_idx_r;
  logic [FW-1:0]         frame_r;
  logic                  kern_r;
  logic                  wr_r;
  logic [TBL_W-1:0]      tab_r;
  logic                  pend_ok_r;
  logic [FW-1:0]         pend_page_r;
  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [FW-1:0]         out_page_r;

  // Memory ports
  logic                  dir_we;
  logic [IW-1:0]         dir_waddr;
  logic [DIR_W-1:0]      dir_wdata;
  logic [IW-1:0]         dir_raddr;
  logic [DIR_W-1:0]      dir_rdata;
  logic                  leaf_we;
  logic [LEAF_AW-1:0]    leaf_waddr;
  tlpt_pkg::leaf_t       leaf_wdata;
  logic [LEAF_AW-1:0]    leaf_raddr;
  tlpt_pkg::leaf_t       leaf_rdata;

  // Decode of the directory word and the request
  logic                  dir_have;
  logic [TBL_W-1:0]      dir_tab;
  logic                  pool_avail;
  logic [TBL_W-1:0]      new_tab;
  logic                  alloc;
  logic                  go_leaf;
  logic                  fin;
  logic                  fin_ok;
  logic [FW-1:0]         fin_page;
  logic                  out_free;
  logic                  out_load;
  logic                  clr_last;
  tlpt_pkg::leaf_t       map_entry;

  tlpt_dir_mem #(
    .DATA_W (DIR_W)
  ) u_dir_mem (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tlpt_leaf_mem #(
    .DEPTH  (LEAF_DEPTH),
    .ADDR_W (LEAF_AW)
  ) u_leaf_mem (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (leaf_wdata),
    .raddr (leaf_raddr),
    .rdata (leaf_rdata)
  );

  assign dir_have   = dir_rdata[tlpt_pkg::DIR_PRESENT];
  assign dir_tab    = dir_rdata[DIR_W-1:tlpt_pkg::DIR_TAB_LSB];
  assign pool_avail = (next_tab_r < CNT_W'(TABLE_POOL));
  assign new_tab    = TBL_W'(next_tab_r);
  assign out_free   = !out_valid_r || !out_stall;
  assign out_load   = out_free && (fin || (state_r == ST_DONE));
  assign clr_last   = (clr_cnt_r == LEAF_AW'(LEAF_DEPTH - 1));

  // Build the leaf entry that a map writes
  always_comb begin
    map_entry.frame     = frame_r;
    map_entry.global_pg = kern_r;
    map_entry.user      = !kern_r;
    map_entry.rw        = wr_r;
    map_entry.present   = 1'b1;
  end

  // Drive memory accesses and the finishing result
  always_comb begin
    dir_we     = 1'b0;
    dir_waddr  = dir_idx_r;
    dir_wdata  = {new_tab, kern_r, !kern_r, 1'b1};
    dir_raddr  = in_virt_addr[tlpt_pkg::DIR_LSB +: IW];
    leaf_we    = 1'b0;
    leaf_waddr = LEAF_AW'({dir_tab, leaf_idx_r});
    leaf_wdata = map_entry;
    leaf_raddr = LEAF_AW'({dir_tab, leaf_idx_r});
    alloc      = 1'b0;
    go_leaf    = 1'b0;
    fin        = 1'b0;
    fin_ok     = 1'b0;
    fin_page   = '0;
    unique case (state_r)
      ST_CLEAR: begin
        dir_we     = 1'b1;
        dir_waddr  = clr_cnt_r[IW-1:0];
        dir_wdata  = '0;
        leaf_we    = 1'b1;
        leaf_waddr = clr_cnt_r;
        leaf_wdata = '0;
      end
      ST_DIR: begin
        unique case (cmd_r) inside
          tlpt_pkg::CMD_LOOKUP, tlpt_pkg::CMD_UNMAP: begin
            go_leaf = dir_have;
            fin     = !dir_have;
          end
          tlpt_pkg::CMD_MAP: begin
            fin = 1'b1;
            if (dir_have) begin
              leaf_we = 1'b1;
              fin_ok  = 1'b1;
            end else if (pool_avail) begin
              alloc      = 1'b1;
              dir_we     = 1'b1;
              leaf_we    = 1'b1;
              leaf_waddr = LEAF_AW'({new_tab, leaf_idx_r});
              fin_ok     = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_LEAF: begin
        fin        = 1'b1;
        leaf_waddr = LEAF_AW'({tab_r, leaf_idx_r});
        if (cmd_r == tlpt_pkg::CMD_UNMAP) begin
          // Clear the present mark, keep the rest of the entry
          leaf_we            = 1'b1;
          leaf_wdata         = leaf_rdata;
          leaf_wdata.present = 1'b0;
          fin_ok             = 1'b1;
        end else begin
          fin_ok   = leaf_rdata.present;
          fin_page = leaf_rdata.present ? leaf_rdata.frame : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequence each item and hold the result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      next_tab_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a finished result, or drop the one just taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r) inside
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r      <= in_cmd;
            dir_idx_r  <= in_virt_addr[tlpt_pkg::DIR_LSB +: IW];
            leaf_idx_r <= in_virt_addr[tlpt_pkg::LEAF_LSB +: IW];
            frame_r    <= in_phys_page;
            kern_r     <= in_flag_kernel;
            wr_r       <= in_flag_writable;
            state_r    <= ST_DIR;
          end
        end
        ST_DIR, ST_LEAF: begin
          if (state_r == ST_DIR) begin
            tab_r <= dir_tab;
          end
          if (alloc) begin
            next_tab_r <= next_tab_r + 1'b1;
          end
          if (go_leaf) begin
            state_r <= ST_LEAF;
          end else if (fin) begin
            if (out_free) begin
              out_ok_r    <= fin_ok;
              out_page_r  <= fin_page;
              state_r     <= ST_IDLE;
            end else begin
              pend_ok_r   <= fin_ok;
              pend_page_r <= fin_page;
              state_r     <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_ok_r    <= pend_ok_r;
            out_page_r  <= pend_page_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_found_page = out_page_r;

endmodule

// ===== tb/testbench.sv =====
// Testbench for the two-level page table engine: directed and random requests against a mirror.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned POOL_TABLES    = 4;
  localparam logic [1:0]  CMD_RSVD       = 2'd3;
  localparam int unsigned RANDOM_ITEMS   = 1550;
  localparam int unsigned QUIET_FIRST    = 700;
  localparam int unsigned QUIET_LAST     = 1000;
  localparam int unsigned IDLE_PERCENT   = 22;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam logic [9:0]  IDX_TOP        = 10'h3ff;

  // Directory entry as the mirror keeps it
  typedef struct packed {
    logic [2:0] tab;
    logic       global_pg;
    logic       user;
    logic       present;
  } dir_ent_t;

  typedef struct packed {
    logic                         ok;
    logic [tlpt_pkg::FRAME_W-1:0] page;
  } walk_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = tlpt_pkg::CMD_LOOKUP;
  logic [31:0] in_virt_addr = '0;
  logic [19:0] in_phys_page = '0;
  logic        in_flag_kernel = 1'b0;
  logic        in_flag_writable = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok;
  logic [19:0] out_found_page;

  // Mirror of the page table state
  dir_ent_t        dir_mirror [tlpt_pkg::DIR_DEPTH];
  tlpt_pkg::leaf_t leaf_mirror [POOL_TABLES*tlpt_pkg::LEAF_SPAN];
  int unsigned     tables_used;

  walk_result_t expected_walks [$];
  int unsigned  errors = 0;
  int unsigned  idle_cycles = 0;
  logic         idle_en = 1'b1;
  logic         stall_en = 1'b1;
  logic [9:0]   hot_dirs [4] = '{10'd0, 10'd5, 10'd512, IDX_TOP};

  two_level_page_table_engine #(
    .TABLE_POOL(POOL_TABLES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_virt_addr(in_virt_addr),
    .in_phys_page(in_phys_page),
    .in_flag_kernel(in_flag_kernel),
    .in_flag_writable(in_flag_writable),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_ok(out_ok),
    .out_found_page(out_found_page)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Walk the mirror for one request and apply its side effects
  function automatic walk_result_t apply_request(logic [1:0] cmd, logic [31:0] va,
                                                 logic [19:0] pg, logic kern, logic wr);
    logic [9:0]      di;
    logic [9:0]      li;
    dir_ent_t        de;
    tlpt_pkg::leaf_t le;
    logic            have;
    int unsigned     slot;
    walk_result_t    res;
    di = va[tlpt_pkg::DIR_LSB +: tlpt_pkg::IDX_W];
    li = va[tlpt_pkg::LEAF_LSB +: tlpt_pkg::IDX_W];
    de = dir_mirror[di];
    have = de.present && (de.tab < POOL_TABLES);
    slot = de.tab * tlpt_pkg::LEAF_SPAN + li;
    res = '0;
    case (cmd)
      tlpt_pkg::CMD_LOOKUP: begin
        if (have && leaf_mirror[slot].present) begin
          res.ok = 1'b1;
          res.page = leaf_mirror[slot].frame;
        end
      end
      tlpt_pkg::CMD_MAP: begin
        // take the next pool table for an empty directory slot
        if (!have && tables_used < POOL_TABLES) begin
          de = '0;
          de.present = 1'b1;
          de.user = !kern;
          de.global_pg = kern;
          de.tab = tables_used[2:0];
          dir_mirror[di] = de;
          tables_used++;
          have = 1'b1;
          slot = de.tab * tlpt_pkg::LEAF_SPAN + li;
        end
        if (have) begin
          le.frame = pg;
          le.global_pg = kern;
          le.user = !kern;
          le.rw = wr;
          le.present = 1'b1;
          leaf_mirror[slot] = le;
          res.ok = 1'b1;
        end
      end
      tlpt_pkg::CMD_UNMAP: begin
        if (have) begin
          leaf_mirror[slot].present = 1'b0;
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] make_va(logic [9:0] di, logic [9:0] li, logic [11:0] off);
    return {di, li, off};
  endfunction

  // Drive one item from a falling edge and hold it until accepted
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] va,
                              input logic [19:0] pg, input logic kern, input logic wr);
    if (idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < IDLE_PERCENT);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_virt_addr <= va;
    in_phys_page <= pg;
    in_flag_kernel <= kern;
    in_flag_writable <= wr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_walks.push_back(apply_request(cmd, va, pg, kern, wr));
    @(negedge clk);
  endtask

  task automatic test_empty_tables();
    send_request(tlpt_pkg::CMD_LOOKUP, 32'h0, 20'h0, 1'b0, 1'b0);
    send_request(tlpt_pkg::CMD_UNMAP, 32'h0, 20'h0, 1'b0, 1'b0);
  endtask

  task automatic test_map_and_lookup();
    send_request(tlpt_pkg::CMD_MAP, 32'h0, 20'hfffff, 1'b1, 1'b1);
    send_request(tlpt_pkg::CMD_LOOKUP, 32'h0, 20'h0, 1'b0, 1'b0);
    send_request(tlpt_pkg::CMD_MAP, 32'hffff_ffff, 20'h0, 1'b0, 1'b0);
    send_request(tlpt_pkg::CMD_LOOKUP, 32'hffff_ffff, 20'hfffff, 1'b1, 1'b1);
    // reuse the table of an existing directory entry
    send_request(tlpt_pkg::CMD_MAP, make_va(10'd0, 10'd1, 12'hfff), 20'h12345, 1'b0, 1'b1);
    send_request(tlpt_pkg::CMD_LOOKUP, make_va(10'd0, 10'd1, 12'h0), 20'h0, 1'b0, 1'b0);
    send_request(tlpt_pkg::CMD_LOOKUP, make_va(10'd0, 10'd2, 12'h0), 20'h0, 1'b0, 1'b0);
  endtask

  task automatic test_remap_and_unmap();
    send_request(tlpt_pkg::CMD_MAP, make_va(10'd0, 10'd0, 12'h800), 20'habcde, 1'b0, 1'b0);
    send_request(tlpt_pkg::CMD_LOOKUP, 32'h0, 20'h0, 1'b0, 1'b0);
    send_request(tlpt_pkg::CMD_UNMAP, 32'h0, 20'h0, 1'b0, 1'b0);
    send_request(tlpt_pkg::CMD_LOOKUP, 32'h0, 20'h0, 1'b0, 1'b0);
    // clear an absent leaf again
    send_request(tlpt_pkg::CMD_UNMAP, 32'h0, 20'hfffff, 1'b1, 1'b1);
  endtask

  task automatic test_reserved_cmd();
    send_request(CMD_RSVD, 32'hffff_ffff, 20'hfffff, 1'b1, 1'b1);
    send_request(tlpt_pkg::CMD_LOOKUP, 32'hffff_ffff, 20'h0, 1'b0, 1'b0);
  endtask

  task automatic test_pool_exhaustion();
    send_request(tlpt_pkg::CMD_MAP, make_va(10'd512, 10'd7, 12'h0), 20'h55555, 1'b1, 1'b0);
    send_request(tlpt_pkg::CMD_MAP, make_va(10'd5, 10'd9, 12'h0), 20'haaaaa, 1'b0, 1'b1);
    send_request(tlpt_pkg::CMD_MAP, make_va(10'd7, 10'd3, 12'h0), 20'h00001, 1'b0, 1'b1);
    send_request(tlpt_pkg::CMD_LOOKUP, make_va(10'd7, 10'd3, 12'h0), 20'h0, 1'b0, 1'b0);
    send_request(tlpt_pkg::CMD_UNMAP, make_va(10'd7, 10'd3, 12'h0), 20'h0, 1'b0, 1'b0);
    send_request(tlpt_pkg::CMD_LOOKUP, make_va(10'd5, 10'd9, 12'h0), 20'h0, 1'b0, 1'b0);
  endtask

  // Mostly hot directories and a small leaf set so lookups hit; some fully random noise
  task automatic test_random_traffic();
    logic [31:0] rnd;
    logic [9:0]  di;
    logic [9:0]  li;
    logic [1:0]  cmd;
    int unsigned pick;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      idle_en = !(n >= QUIET_FIRST && n < QUIET_LAST);
      stall_en = idle_en;
      rnd = $urandom();
      if ($urandom_range(0, 99) < 85) di = hot_dirs[$urandom_range(0, 3)];
      else di = 10'($urandom_range(0, IDX_TOP));
      if ($urandom_range(0, 9) < 8) li = 10'($urandom_range(0, 15) * 61);
      else li = 10'($urandom_range(0, IDX_TOP));
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd = tlpt_pkg::CMD_LOOKUP;
      else if (pick < 70) cmd = tlpt_pkg::CMD_MAP;
      else if (pick < 92) cmd = tlpt_pkg::CMD_UNMAP;
      else cmd = CMD_RSVD;
      send_request(cmd, make_va(di, li, rnd[11:0]), 20'($urandom_range(0, 20'hfffff)),
                   rnd[12], rnd[13]);
    end
    idle_en = 1'b1;
    stall_en = 1'b1;
  endtask

  // Random backpressure on the result channel
  always @(negedge clk) begin
    out_stall <= stall_en && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    walk_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_walks.size() == 0) begin
        $display("%0t: unexpected result ok=%0b found_page=%05h", $time, out_ok,
                 out_found_page);
        errors++;
      end else begin
        exp_res = expected_walks.pop_front();
        if (out_ok !== exp_res.ok) begin
          $display("%0t: ok mismatch expected %0b actual %0b", $time, exp_res.ok, out_ok);
          errors++;
        end
        if (out_found_page !== exp_res.page) begin
          $display("%0t: found_page mismatch expected %05h actual %05h", $time,
                   exp_res.page, out_found_page);
          errors++;
        end
      end
    end
  end

  // Abort when no item moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int unsigned i = 0; i < tlpt_pkg::DIR_DEPTH; i++) dir_mirror[i] = '0;
    for (int unsigned i = 0; i < POOL_TABLES*tlpt_pkg::LEAF_SPAN; i++) leaf_mirror[i] = '0;
    tables_used = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_tables();
    test_map_and_lookup();
    test_remap_and_unmap();
    test_reserved_cmd();
    test_pool_exhaustion();
    test_random_traffic();
    in_valid <= 1'b0;
    // drain outstanding results, then watch for strays
    while (expected_walks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tlpt_pkg.sv
rtl/core/tlpt_dir_mem.sv
rtl/core/tlpt_leaf_mem.sv
rtl/core/two_level_page_table_engine.sv
tb/testbench.sv
